/* rtl/core/sct_pkg.sv */
// Shared types and constants for the shell command tokenizer.
// Token kind and quote codes, byte codes, record and record-group types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sct_pkg;

	localparam int KIND_W     = 3;
	localparam int QUOTE_W    = 2;
	localparam int POS_OUT_W  = 13;
	localparam int MAX_REC    = 3;
	localparam int CNT_W      = 2;
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = 2;

	localparam logic [KIND_W-1:0] KIND_WORD   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_PIPE   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_IN     = 3'd2;
	localparam logic [KIND_W-1:0] KIND_OUT    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_APPEND = 3'd4;
	localparam logic [KIND_W-1:0] KIND_END    = 3'd5;

	// lexer mode and quote kind share one encoding
	localparam logic [QUOTE_W-1:0] MODE_UNQ = 2'd0;
	localparam logic [QUOTE_W-1:0] MODE_SQ  = 2'd1;
	localparam logic [QUOTE_W-1:0] MODE_DQ  = 2'd2;

	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_PIPE   = 8'h7C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;

	typedef struct packed {
		logic [KIND_W-1:0]    kind;
		logic [QUOTE_W-1:0]   quote;
		logic [POS_OUT_W-1:0] first_pos;
		logic [POS_OUT_W-1:0] end_pos;
	} rec_t;

	// up to three records caused by one byte; cnt is 1..3 once queued
	typedef struct packed {
		rec_t [MAX_REC-1:0] rec;
		logic [CNT_W-1:0]   cnt;
	} bundle_t;

	function automatic rec_t mk_rec(
		input logic [KIND_W-1:0]    kind,
		input logic [QUOTE_W-1:0]   quote,
		input logic [POS_OUT_W-1:0] s,
		input logic [POS_OUT_W-1:0] e
	);
		rec_t r;
		r.kind      = kind;
		r.quote     = quote;
		r.first_pos = s;
		r.end_pos   = e;
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/sct_ifs.sv */
// Valid/ready channel interfaces for the tokenizer: byte input and token output.
// Depends on sct_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface sct_byte_if;
	import sct_pkg::*;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       last_byte;

	modport source (output valid, output ch, output last_byte, input ready);
	modport sink   (input valid, input ch, input last_byte, output ready);
endinterface

interface sct_tok_if;
	import sct_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [KIND_W-1:0]    token_kind;
	logic [QUOTE_W-1:0]   quote_kind;
	logic [POS_OUT_W-1:0] first_pos;
	logic [POS_OUT_W-1:0] end_pos;
	logic                 run_last;

	modport source (output valid, output token_kind, output quote_kind, output first_pos,
		output end_pos, output run_last, input ready);
	modport sink   (input valid, input token_kind, input quote_kind, input first_pos,
		input end_pos, input run_last, output ready);
endinterface

`default_nettype wire

/* rtl/core/shell_command_tokenizer.sv */
// Top level of the shell command tokenizer: input register, lexer step, record queue.
// Depends on sct_pkg, sct_ifs, sct_lexer and sct_bundle_fifo.
//
//   channel  dir   beat
//   cmd      in    one command-line byte: ch, last_byte
//   tok      out   one token record: token_kind, quote_kind, first_pos, end_pos, run_last
//
// A byte is registered on acceptance and lexed while the queue is not full; its records
// are written into the record queue and appear on tok from its head.
// cmd takes one byte per cycle while the four-group record queue has room;
// tok delivers one record per cycle while ready is high, a byte's records in order.
// arst_n clears the lexer state, the input valid flag and the queue pointers.
// A stall on tok fills the queue, and then cmd drops ready.
`timescale 1ns / 1ps
`default_nettype none

module shell_command_tokenizer #(
	parameter int MAX_LINE = 4096
) (
	input wire logic  clk,
	input wire logic  arst_n,
	sct_byte_if.sink  cmd,
	sct_tok_if.source tok
);
	import sct_pkg::*;

	logic             v_s1;
	logic [7:0]       ch_s1;
	logic             last_s1;
	logic             step;
	bundle_t          grp;
	bundle_t          head;
	logic             fifo_full, fifo_empty;
	logic             push, pop;
	logic [CNT_W-1:0] idx_q;
	logic             rec_last;
	rec_t             cur;

	assign step      = v_s1 && !fifo_full;
	assign push      = step && (grp.cnt != '0);
	assign cmd.ready = !v_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (cmd.ready) begin
			v_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			ch_s1   <= cmd.ch;
			last_s1 <= cmd.last_byte;
		end
	end

	sct_lexer #(
		.MAX_LINE(MAX_LINE)
	) u_lexer (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.ch        (ch_s1),
		.last_byte (last_s1),
		.grp       (grp)
	);

	sct_bundle_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (grp),
		.pop    (pop),
		.head   (head),
		.full   (fifo_full),
		.empty  (fifo_empty)
	);

	// walk the records of the head group, one per beat
	assign cur      = head.rec[idx_q];
	assign rec_last = (idx_q == head.cnt - CNT_W'(1));
	assign pop      = tok.valid && tok.ready && rec_last;

	assign tok.valid      = !fifo_empty;
	assign tok.token_kind = cur.kind;
	assign tok.quote_kind = cur.quote;
	assign tok.first_pos  = cur.first_pos;
	assign tok.end_pos    = cur.end_pos;
	assign tok.run_last   = rec_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (tok.valid && tok.ready) begin
			idx_q <= rec_last ? '0 : idx_q + CNT_W'(1);
		end
	end

`ifndef ASSERT_OFF
	a_head_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		!fifo_empty |-> head.cnt != '0)
		else $error("queued record group is empty");

	a_idx_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		!fifo_empty |-> idx_q < head.cnt)
		else $error("record index beyond its group");

	a_line_end_emits: assert property (@(posedge clk) disable iff (!arst_n)
		step && last_s1 |-> push)
		else $error("final byte produced no records");

	a_idle_index: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_empty |-> idx_q == '0)
		else $error("record index not cleared with empty queue");
`endif

endmodule

`default_nettype wire

/* rtl/core/sct_lexer.sv */
// Lexer state and single-byte step logic: produces the record group for one byte.
// Depends on sct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sct_lexer #(
	parameter int MAX_LINE = 4096
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire logic [7:0]       ch,
	input  wire logic             last_byte,
	output sct_pkg::bundle_t      grp
);
	import sct_pkg::*;

	localparam int POS_W = $clog2(MAX_LINE + 1);
	localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_LINE);
	localparam int NSLOT = 6;

	logic [QUOTE_W-1:0] mode_q, quote_q;
	logic               pgt_q, started_q, nonempty_q;
	logic [POS_W-1:0]   tstart_q, bpos_q;

	logic [QUOTE_W-1:0] mode_d, quote_d;
	logic               pgt_d, started_d, nonempty_d;
	logic [POS_W-1:0]   tstart_d, bpos_d;

	logic [NSLOT-1:0]   sv;
	rec_t               sr [NSLOT];
	logic [POS_W-1:0]   pos, nxt;
	logic               is_ws;

	assign pos   = bpos_q;
	assign nxt   = (bpos_q == MAX_POS) ? MAX_POS : bpos_q + POS_W'(1);
	assign is_ws = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);

	// slots in emission order: pending '>', word flush, operator,
	// trailing '>', final word flush, end of line
	always_comb begin
		logic         done;
		logic [7:0]   closer;
		mode_d     = mode_q;
		quote_d    = quote_q;
		pgt_d      = pgt_q;
		started_d  = started_q;
		nonempty_d = nonempty_q;
		tstart_d   = tstart_q;
		bpos_d     = nxt;
		done       = 1'b0;
		closer     = (mode_q == MODE_SQ) ? CH_SQUOTE : CH_DQUOTE;
		sv         = '0;
		for (int i = 0; i < NSLOT; i++) begin
			sr[i] = '0;
		end

		if (pgt_q) begin
			pgt_d = 1'b0;
			sv[0] = 1'b1;
			if (ch == CH_GT) begin
				sr[0]    = mk_rec(KIND_APPEND, MODE_UNQ, POS_OUT_W'(tstart_q),
					POS_OUT_W'(pos));
				tstart_d = nxt;
				done     = 1'b1;
			end else begin
				sr[0]    = mk_rec(KIND_OUT, MODE_UNQ, POS_OUT_W'(tstart_q),
					POS_OUT_W'(tstart_q));
				tstart_d = pos;
			end
		end

		if (!done) begin
			if (mode_q == MODE_SQ || mode_q == MODE_DQ) begin
				if (ch == closer) begin
					if (nonempty_d) begin
						sv[1]      = 1'b1;
						sr[1]      = mk_rec(KIND_WORD, quote_d, POS_OUT_W'(tstart_d),
							POS_OUT_W'(pos));
						nonempty_d = 1'b0;
						started_d  = 1'b0;
					end
					mode_d   = MODE_UNQ;
					quote_d  = MODE_UNQ;
					tstart_d = nxt;
				end else begin
					nonempty_d = 1'b1;
				end
			end else if (ch == CH_SQUOTE || ch == CH_DQUOTE || ch == CH_PIPE ||
				ch == CH_LT || ch == CH_GT || is_ws) begin
				// delimiter: close any open word first
				if (nonempty_d) begin
					sv[1]      = 1'b1;
					sr[1]      = mk_rec(KIND_WORD, quote_d, POS_OUT_W'(tstart_d),
						POS_OUT_W'(pos));
					nonempty_d = 1'b0;
					started_d  = 1'b0;
				end
				tstart_d = nxt;
				if (ch == CH_SQUOTE || ch == CH_DQUOTE) begin
					mode_d  = (ch == CH_SQUOTE) ? MODE_SQ : MODE_DQ;
					quote_d = mode_d;
				end else if (ch == CH_PIPE || ch == CH_LT) begin
					sv[2] = 1'b1;
					sr[2] = mk_rec((ch == CH_PIPE) ? KIND_PIPE : KIND_IN, MODE_UNQ,
						POS_OUT_W'(pos), POS_OUT_W'(pos));
				end else if (ch == CH_GT) begin
					pgt_d    = 1'b1;
					tstart_d = pos;
				end
			end else begin
				mode_d  = MODE_UNQ;
				quote_d = MODE_UNQ;
				if (!started_d) begin
					tstart_d  = pos;
					started_d = 1'b1;
				end
				nonempty_d = 1'b1;
			end
		end

		if (last_byte) begin
			if (pgt_d) begin
				sv[3] = 1'b1;
				sr[3] = mk_rec(KIND_OUT, MODE_UNQ, POS_OUT_W'(tstart_d),
					POS_OUT_W'(tstart_d));
			end
			if (nonempty_d) begin
				sv[4] = 1'b1;
				sr[4] = mk_rec(KIND_WORD, quote_d, POS_OUT_W'(tstart_d), POS_OUT_W'(nxt));
			end
			sv[5]      = 1'b1;
			sr[5]      = mk_rec(KIND_END, MODE_UNQ, POS_OUT_W'(nxt), POS_OUT_W'(nxt));
			// line done: back to the reset state
			mode_d     = MODE_UNQ;
			quote_d    = MODE_UNQ;
			pgt_d      = 1'b0;
			started_d  = 1'b0;
			nonempty_d = 1'b0;
			tstart_d   = '0;
			bpos_d     = '0;
		end
	end

	// pack the live slots; anything past the third record is dropped
	always_comb begin
		logic [CNT_W:0] n;
		n   = '0;
		grp = '0;
		for (int i = 0; i < NSLOT; i++) begin
			if (sv[i] && n < (CNT_W+1)'(MAX_REC)) begin
				grp.rec[n[CNT_W-1:0]] = sr[i];
				n = n + (CNT_W+1)'(1);
			end
		end
		grp.cnt = n[CNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_UNQ;
			quote_q    <= MODE_UNQ;
			pgt_q      <= 1'b0;
			started_q  <= 1'b0;
			nonempty_q <= 1'b0;
			tstart_q   <= '0;
			bpos_q     <= '0;
		end else if (step) begin
			mode_q     <= mode_d;
			quote_q    <= quote_d;
			pgt_q      <= pgt_d;
			started_q  <= started_d;
			nonempty_q <= nonempty_d;
			tstart_q   <= tstart_d;
			bpos_q     <= bpos_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/sct_bundle_fifo.sv */
// Small queue of record groups between the lexer step and the token output.
// Depends on sct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sct_bundle_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  sct_pkg::bundle_t      wdata,
	input  wire logic             pop,
	output sct_pkg::bundle_t      head,
	output logic                  full,
	output logic                  empty
);
	import sct_pkg::*;

	bundle_t          mem [FIFO_DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [PTR_W:0]   count_q;

	assign full  = (count_q == (PTR_W+1)'(FIFO_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + PTR_W'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PTR_W+1)'(1);
			end
		end
	end

endmodule

`default_nettype wire
